[src/cfo_pkg.sv]
`timescale 1ns / 1ps

package cfo_pkg;

  localparam int unsigned Depth = 64;
  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CapW  = $clog2(Depth + 1);
  localparam int unsigned SumW  = AddrW + 1;

  typedef enum logic [1:0] {
    OP_PUSH     = 2'd0,
    OP_POP      = 2'd1,
    OP_OVR_PUSH = 2'd2,
    OP_READ_AT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic            rd;
    status_e         status;
    logic [CapW-1:0] count;
    logic            full;
    logic            empty;
    logic            ovf;
    logic            unf;
  } res_t;

  function automatic logic [AddrW-1:0] adv(input logic [AddrW-1:0] p,
                                           input logic [CapW-1:0]  cap);
    logic [CapW-1:0] nxt;
    nxt = CapW'(p) + CapW'(1);
    return (nxt >= cap) ? '0 : nxt[AddrW-1:0];
  endfunction

endpackage

[src/cfo_intf.sv]
`timescale 1ns / 1ps

interface cfo_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                opcode;
  logic [cfo_pkg::DataW-1:0] value;
  logic [cfo_pkg::AddrW-1:0] index;

  modport source (output valid, output opcode, output value, output index, input ready);
  modport sink   (input valid, input opcode, input value, input index, output ready);
endinterface

interface cfo_out_if;
  logic                      valid;
  logic                      ready;
  logic [cfo_pkg::DataW-1:0] data_out;
  logic [1:0]                status;
  logic [cfo_pkg::CapW-1:0]  count;
  logic                      is_full;
  logic                      is_empty;
  logic                      overflow_seen;
  logic                      underflow_seen;

  modport source (output valid, output data_out, output status, output count,
                  output is_full, output is_empty, output overflow_seen,
                  output underflow_seen, input ready);
  modport sink   (input valid, input data_out, input status, input count,
                  input is_full, input is_empty, input overflow_seen,
                  input underflow_seen, output ready);
endinterface

interface cfo_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [cfo_pkg::CapW-1:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

[src/circular_fifo_with_overwrite.sv]
// Ring-buffer FIFO of 64 words of 32 bits with a capacity register (1..64; 0 acts as 1,
// above 64 acts as 64). Each input beat carries one operation (push, pop, overwrite push,
// read at age index) and yields exactly one output beat with the data word, a status code,
// the count after the operation, full and empty, and the overflow and underflow
// flags. Pointer, count and flag updates finish in the cycle a beat is taken, and the
// storage array is read through its registered port, so one operation is taken every
// clock cycle while the output side keeps up; a stalled output beat holds the input off.
// Writing the capacity empties the queue and clears both flags; write it only while idle.
`timescale 1ns / 1ps

module circular_fifo_with_overwrite (
  input  logic      clk_i,
  input  logic      rst_ni,
  cfo_in_if.sink    in_if,
  cfo_out_if.source out_if,
  cfo_cfg_if.sink   cfg_if
);

  cfo_pkg::ram_req_t         ram_req;
  cfo_pkg::res_t             res_d;
  cfo_pkg::res_t             res_q;
  logic                      out_valid_q;
  logic                      in_fire;
  logic                      cfg_fire;
  logic [cfo_pkg::DataW-1:0] rdata;

  assign in_if.ready  = !out_valid_q || out_if.ready;
  assign cfg_if.ready = 1'b1;
  assign in_fire      = in_if.valid && in_if.ready;
  assign cfg_fire     = cfg_if.valid && cfg_if.ready;

  cfo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (in_fire),
    .opcode_i   (in_if.opcode),
    .value_i    (in_if.value),
    .index_i    (in_if.index),
    .cfg_fire_i (cfg_fire),
    .cfg_cap_i  (cfg_if.capacity),
    .ram_req_o  (ram_req),
    .res_o      (res_d)
  );

  cfo_ram #(
    .Depth (cfo_pkg::Depth),
    .Width (cfo_pkg::DataW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.data_out       = res_q.rd ? rdata : '0;
  assign out_if.status         = res_q.status;
  assign out_if.count          = res_q.count;
  assign out_if.is_full        = res_q.full;
  assign out_if.is_empty       = res_q.empty;
  assign out_if.overflow_seen  = res_q.ovf;
  assign out_if.underflow_seen = res_q.unf;

endmodule

[src/cfo_ram.sv]
`timescale 1ns / 1ps

module cfo_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/cfo_ctrl.sv]
`timescale 1ns / 1ps

module cfo_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fire_i,
  input  logic [1:0]                        opcode_i,
  input  logic [cfo_pkg::DataW-1:0]         value_i,
  input  logic [cfo_pkg::AddrW-1:0]         index_i,
  input  logic                              cfg_fire_i,
  input  logic [cfo_pkg::CapW-1:0]          cfg_cap_i,
  output cfo_pkg::ram_req_t                 ram_req_o,
  output cfo_pkg::res_t                     res_o
);

  logic [cfo_pkg::AddrW-1:0] wp_q, wp_d;
  logic [cfo_pkg::AddrW-1:0] rp_q, rp_d;
  logic [cfo_pkg::CapW-1:0]  cnt_q, cnt_d;
  logic [cfo_pkg::CapW-1:0]  cap_q, cap_d;
  logic                      ovf_q, ovf_d;
  logic                      unf_q, unf_d;

  logic                      full;
  logic [cfo_pkg::SumW-1:0]  sum;
  logic [cfo_pkg::SumW-1:0]  wrap;
  logic [cfo_pkg::CapW-1:0]  cfg_clamped;
  cfo_pkg::op_e              op;

  assign op   = cfo_pkg::op_e'(opcode_i);
  assign full = (cnt_q >= cap_q);
  assign sum  = cfo_pkg::SumW'(rp_q) + cfo_pkg::SumW'(index_i);
  assign wrap = (cfo_pkg::CapW'(sum) >= cap_q) ? sum - cfo_pkg::SumW'(cap_q) : sum;

  always_comb begin
    if (cfg_cap_i == '0) begin
      cfg_clamped = cfo_pkg::CapW'(1);
    end else if (cfg_cap_i > cfo_pkg::CapW'(cfo_pkg::Depth)) begin
      cfg_clamped = cfo_pkg::CapW'(cfo_pkg::Depth);
    end else begin
      cfg_clamped = cfg_cap_i;
    end
  end

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    cap_d = cap_q;
    ovf_d = ovf_q;
    unf_d = unf_q;
    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = wp_q;
    ram_req_o.wdata = value_i;
    ram_req_o.re    = 1'b0;
    ram_req_o.raddr = rp_q;
    res_o.rd        = 1'b0;
    res_o.status    = cfo_pkg::ST_OK;

    if (fire_i) begin
      unique case (op)
        cfo_pkg::OP_PUSH: begin
          if (full) begin
            ovf_d        = 1'b1;
            res_o.status = cfo_pkg::ST_FULL;
          end else begin
            ram_req_o.we = 1'b1;
            wp_d         = cfo_pkg::adv(wp_q, cap_q);
            cnt_d        = cnt_q + cfo_pkg::CapW'(1);
            unf_d        = 1'b0;
          end
        end
        cfo_pkg::OP_POP: begin
          if (cnt_q == '0) begin
            unf_d        = 1'b1;
            res_o.status = cfo_pkg::ST_EMPTY;
          end else begin
            ram_req_o.re = 1'b1;
            res_o.rd     = 1'b1;
            rp_d         = cfo_pkg::adv(rp_q, cap_q);
            cnt_d        = cnt_q - cfo_pkg::CapW'(1);
            ovf_d        = 1'b0;
          end
        end
        cfo_pkg::OP_OVR_PUSH: begin
          ram_req_o.we = 1'b1;
          wp_d         = cfo_pkg::adv(wp_q, cap_q);
          unf_d        = 1'b0;
          if (full) begin
            rp_d  = cfo_pkg::adv(rp_q, cap_q);
            ovf_d = 1'b0;
          end else begin
            cnt_d = cnt_q + cfo_pkg::CapW'(1);
          end
        end
        cfo_pkg::OP_READ_AT: begin
          if (cfo_pkg::CapW'(index_i) < cnt_q) begin
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = wrap[cfo_pkg::AddrW-1:0];
            res_o.rd        = 1'b1;
          end else begin
            res_o.status = cfo_pkg::ST_RANGE;
          end
        end
      endcase
    end

    if (cfg_fire_i) begin
      cap_d = cfg_clamped;
      wp_d  = '0;
      rp_d  = '0;
      cnt_d = '0;
      ovf_d = 1'b0;
      unf_d = 1'b0;
    end

    res_o.count = cnt_d;
    res_o.full  = (cnt_d == cap_d);
    res_o.empty = (cnt_d == '0);
    res_o.ovf   = ovf_d;
    res_o.unf   = unf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
      cap_q <= cfo_pkg::CapW'(cfo_pkg::Depth);
      ovf_q <= 1'b0;
      unf_q <= 1'b0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
      cap_q <= cap_d;
      ovf_q <= ovf_d;
      unf_q <= unf_d;
    end
  end

  a_cnt_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cap_q) else $error("count above capacity");

  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfo_pkg::CapW'(wp_q) < cap_q) && (cfo_pkg::CapW'(rp_q) < cap_q))
    else $error("pointer beyond capacity");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ovf_q && unf_q)) else $error("overflow and underflow both set");

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_fire_i |=> (cnt_q == '0) && (wp_q == '0) && (rp_q == '0))
    else $error("capacity write did not clear queue");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) && (cnt_q != cap_q) |-> (wp_q != rp_q))
    else $error("pointers meet on partly filled queue");

endmodule
